/* sv/odo_pkg.sv */
// Shared types and constants for the planar odometry integrator.
// Holds the sequencer state type, register indexes and the CORDIC tables.
// No dependencies.
package odo_pkg;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned OUT_DATA_W = 176;

  typedef logic [CFG_IDX_W-1:0]  cfg_index_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [IN_DATA_W-1:0]  in_data_t;
  typedef logic [OUT_DATA_W-1:0] out_data_t;

  // register indexes
  localparam cfg_index_t REG_TICK_PERIOD   = 8'd0;
  localparam cfg_index_t REG_START_X       = 8'd1;
  localparam cfg_index_t REG_START_Y       = 8'd2;
  localparam cfg_index_t REG_START_HEADING = 8'd3;

  // register reset values
  localparam logic [19:0]        TICK_PERIOD_RST = 20'd10486;
  localparam logic signed [31:0] START_X_RST     = 32'sd32768;
  localparam logic signed [31:0] START_Y_RST     = -32'sd9830;
  localparam logic [15:0]        START_HEAD_RST  = 16'd16384;

  // 1/(2*pi) in Q0.32 and the CORDIC start gain in Q2.30
  localparam logic signed [31:0] INV_TWO_PI  = 32'sd683565276;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic [4:0]         CORDIC_LAST = 5'd23;

  // quadrant codes from the top two heading bits
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  // multiply/accumulate schedule steps
  localparam logic [4:0] MS_TURN    = 5'd0;
  localparam logic [4:0] MS_FWD     = 5'd1;
  localparam logic [4:0] MS_SIDE    = 5'd2;
  localparam logic [4:0] MS_ANGLE   = 5'd3;
  localparam logic [4:0] MS_X_FC    = 5'd4;
  localparam logic [4:0] MS_X_SS    = 5'd5;
  localparam logic [4:0] MS_X_SUB   = 5'd6;
  localparam logic [4:0] MS_Y_FS    = 5'd7;
  localparam logic [4:0] MS_Y_SC    = 5'd8;
  localparam logic [4:0] MS_Y_ADD   = 5'd9;
  localparam logic [4:0] MS_Y_WRITE = 5'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_TRIG,
    ST_MUL,
    ST_DONE
  } odo_state_t;

  // arctangent of 2^-i as a 32-bit binary angle with 30 fraction bits per quarter turn
  function automatic logic signed [31:0] arc_angle(input logic [4:0] i);
    logic signed [31:0] a;
    case (i)
      5'd0:    a = 32'sh20000000;
      5'd1:    a = 32'sh12E4051D;
      5'd2:    a = 32'sh09FB385B;
      5'd3:    a = 32'sh051111D4;
      5'd4:    a = 32'sh028B0D43;
      5'd5:    a = 32'sh0145D7E1;
      5'd6:    a = 32'sh00A2F61E;
      5'd7:    a = 32'sh00517C55;
      5'd8:    a = 32'sh0028BE53;
      5'd9:    a = 32'sh00145F2E;
      5'd10:   a = 32'sh000A2F98;
      5'd11:   a = 32'sh000517CC;
      5'd12:   a = 32'sh00028BE6;
      5'd13:   a = 32'sh000145F3;
      5'd14:   a = 32'sh0000A2F9;
      5'd15:   a = 32'sh0000517C;
      5'd16:   a = 32'sh000028BE;
      5'd17:   a = 32'sh0000145F;
      5'd18:   a = 32'sh00000A2F;
      5'd19:   a = 32'sh00000517;
      5'd20:   a = 32'sh0000028B;
      5'd21:   a = 32'sh00000145;
      5'd22:   a = 32'sh000000A2;
      5'd23:   a = 32'sh00000051;
      default: a = 32'sh00000000;
    endcase
    return a;
  endfunction

  // round a Q2.30 CORDIC output half up to Q1.15 and clamp to +-32767
  function automatic logic signed [15:0] to_q15(input logic signed [31:0] v);
    logic signed [32:0] sum;
    logic signed [17:0] r;
    logic signed [15:0] q;
    sum = 33'(v) + 33'sd16384;
    r   = sum[32:15];
    if (r > 18'sd32767) begin
      q = 16'sd32767;
    end else if (r < -18'sd32767) begin
      q = -16'sd32767;
    end else begin
      q = r[15:0];
    end
    return q;
  endfunction

endpackage

/* sv/planar_odometry_integrator.sv */
// Planar dead-reckoning odometry integrator, top level.
// Uses odo_pkg for the state type, register indexes and CORDIC tables.
//
// channel  dir  handshake                  payload (low bit up)
// -------  ---  -------------------------  ----------------------------------------
// in_      in   in_tvalid / in_tready      vel_forward, vel_side, turn_rate
// out_     out  out_tvalid / out_tready    pose_x, pose_y, pose_heading, echo_*
// cfg_     in   cfg_valid / cfg_ready      cfg_index, cfg_data
//
// A tick runs from its transfer through 24 CORDIC iterations of one
// shift/add unit, a rounding step, and 11 steps on a single 32x32 signed
// multiplier with one accumulator, then the output load.
// A new tick is taken only while the sequencer is idle; the output register
// lets one result wait on out_tready while the next tick is already taken.
// Reset (rst_n low, synchronous) loads default registers and the start pose.
// cfg_ready is always high; a start register write presets the pose at once.
module planar_odometry_integrator #(
  parameter int ANGLE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  odo_pkg::in_data_t  in_tdata,   // vel_forward, vel_side, turn_rate
  output logic               out_tvalid,
  input  logic               out_tready,
  output odo_pkg::out_data_t out_tdata,  // pose_x, pose_y, pose_heading,
                                         // echo_forward, echo_side, echo_turn
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  odo_pkg::cfg_index_t cfg_index,
  input  odo_pkg::cfg_data_t  cfg_data
);
  import odo_pkg::*;

  localparam int ZPAD = 32 - ANGLE_BITS;
  localparam int RSH  = 48 - ANGLE_BITS;  // binary-angle rounding shift

  odo_state_t state_r, state_nxt;

  // configuration and pose
  logic [19:0]             tick_period_r, tick_period_nxt;
  logic signed [31:0]      pos_x_r, pos_x_nxt;
  logic signed [31:0]      pos_y_r, pos_y_nxt;
  logic [ANGLE_BITS-1:0]   heading_r, heading_nxt;

  // tick payload
  logic signed [31:0]      vf_r, vf_nxt, vs_r, vs_nxt, vt_r, vt_nxt;

  // CORDIC unit
  logic signed [31:0]      cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  logic [4:0]              cnt_r, cnt_nxt;
  logic signed [15:0]      cos_r, cos_nxt, sin_r, sin_nxt;

  // multiplier and accumulator
  logic signed [31:0]      mul_a, mul_b;
  logic signed [63:0]      mul_p;
  logic signed [63:0]      prod_r, prod_nxt;
  logic signed [49:0]      acc_r, acc_nxt;
  logic signed [31:0]      dfwd_r, dfwd_nxt, dside_r, dside_nxt, dturn_r, dturn_nxt;

  // output register
  logic                    out_valid_r, out_valid_nxt;
  out_data_t               out_data_r, out_data_nxt;

  // combinational helpers
  logic [31:0]             full_ang;
  logic signed [31:0]      xs, ys, arc;
  logic signed [15:0]      cq, sq;
  logic signed [63:0]      step_sum;
  logic [47:0]             ang_sum;
  logic signed [35:0]      pos_sum;
  logic signed [31:0]      pos_sat;
  logic signed [31:0]      pos_old;

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign full_ang = {heading_r, {ZPAD{1'b0}}};
  assign xs       = cx_r >>> cnt_r;
  assign ys       = cy_r >>> cnt_r;
  assign arc      = arc_angle(cnt_r);
  assign cq       = to_q15(cx_r);
  assign sq       = to_q15(cy_r);
  assign mul_p    = mul_a * mul_b;

  // rounded Q16.16 step from a Q16.36 product, and the rounded binary-angle step
  assign step_sum = prod_r + 64'sd524288;
  assign ang_sum  = prod_r[47:0] + (48'd1 << (RSH - 1));

  // round the world step, add it to the position and saturate
  assign pos_old = (cnt_r == MS_Y_FS) ? pos_x_r : pos_y_r;
  assign pos_sum = 36'(pos_old) + 36'($signed(acc_r[49:15]));
  always_comb begin
    if (pos_sum > 36'sd2147483647) begin
      pos_sat = 32'sh7FFFFFFF;
    end else if (pos_sum < -36'sd2147483648) begin
      pos_sat = 32'sh80000000;
    end else begin
      pos_sat = pos_sum[31:0];
    end
  end

  // multiplier operand selection by schedule step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cnt_r)
      MS_TURN: begin
        mul_a = vt_r;
        mul_b = {12'd0, tick_period_r};
      end
      MS_FWD: begin
        mul_a = vf_r;
        mul_b = {12'd0, tick_period_r};
      end
      MS_SIDE: begin
        mul_a = vs_r;
        mul_b = {12'd0, tick_period_r};
      end
      MS_ANGLE: begin
        mul_a = dturn_r;
        mul_b = INV_TWO_PI;
      end
      MS_X_FC: begin
        mul_a = dfwd_r;
        mul_b = 32'(cos_r);
      end
      MS_X_SS: begin
        mul_a = dside_r;
        mul_b = 32'(sin_r);
      end
      MS_Y_FS: begin
        mul_a = dfwd_r;
        mul_b = 32'(sin_r);
      end
      MS_Y_SC: begin
        mul_a = dside_r;
        mul_b = 32'(cos_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    tick_period_nxt = tick_period_r;
    pos_x_nxt       = pos_x_r;
    pos_y_nxt       = pos_y_r;
    heading_nxt     = heading_r;
    vf_nxt          = vf_r;
    vs_nxt          = vs_r;
    vt_nxt          = vt_r;
    cx_nxt          = cx_r;
    cy_nxt          = cy_r;
    cz_nxt          = cz_r;
    cnt_nxt         = cnt_r;
    cos_nxt         = cos_r;
    sin_nxt         = sin_r;
    prod_nxt        = mul_p;
    acc_nxt         = acc_r;
    dfwd_nxt        = dfwd_r;
    dside_nxt       = dside_r;
    dturn_nxt       = dturn_r;
    out_data_nxt    = out_data_r;
    out_valid_nxt   = out_valid_r;

    // drop the held result once it has been transferred
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    // register writes; a start register also presets the pose
    if (cfg_valid) begin
      case (cfg_index)
        REG_TICK_PERIOD:   tick_period_nxt = cfg_data[19:0];
        REG_START_X:       pos_x_nxt = cfg_data;
        REG_START_Y:       pos_y_nxt = cfg_data;
        REG_START_HEADING: heading_nxt = ANGLE_BITS'(cfg_data[15:0]);
        default:           ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          vf_nxt    = in_tdata[31:0];
          vs_nxt    = in_tdata[63:32];
          vt_nxt    = in_tdata[95:64];
          cx_nxt    = CORDIC_GAIN;
          cy_nxt    = '0;
          cz_nxt    = {2'b00, full_ang[29:0]};
          cnt_nxt   = '0;
          state_nxt = ST_CORDIC;
        end
      end

      ST_CORDIC: begin
        // rotate towards zero residual angle, one iteration a cycle
        if (!cz_r[31]) begin
          cx_nxt = cx_r - ys;
          cy_nxt = cy_r + xs;
          cz_nxt = cz_r - arc;
        end else begin
          cx_nxt = cx_r + ys;
          cy_nxt = cy_r - xs;
          cz_nxt = cz_r + arc;
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == CORDIC_LAST) begin
          state_nxt = ST_TRIG;
        end
      end

      ST_TRIG: begin
        // map first-quadrant results to the heading's quadrant
        case (heading_r[ANGLE_BITS-1 -: 2])
          QUAD_0: begin
            cos_nxt = cq;
            sin_nxt = sq;
          end
          QUAD_1: begin
            cos_nxt = -sq;
            sin_nxt = cq;
          end
          QUAD_2: begin
            cos_nxt = -cq;
            sin_nxt = -sq;
          end
          default: begin
            cos_nxt = sq;
            sin_nxt = -cq;
          end
        endcase
        cnt_nxt   = MS_TURN;
        state_nxt = ST_MUL;
      end

      ST_MUL: begin
        // a step may issue one product and consume the one issued in the step before it
        case (cnt_r)
          MS_FWD:     dturn_nxt = step_sum[51:20];
          MS_SIDE:    dfwd_nxt = step_sum[51:20];
          MS_ANGLE:   dside_nxt = step_sum[51:20];
          MS_X_FC:    heading_nxt = heading_r + ang_sum[RSH +: ANGLE_BITS];
          MS_X_SS:    acc_nxt = prod_r[49:0] + 50'sd16384;
          MS_X_SUB:   acc_nxt = acc_r - prod_r[49:0];
          MS_Y_FS:    pos_x_nxt = pos_sat;
          MS_Y_SC:    acc_nxt = prod_r[49:0] + 50'sd16384;
          MS_Y_ADD:   acc_nxt = acc_r + prod_r[49:0];
          MS_Y_WRITE: pos_y_nxt = pos_sat;
          default:    ;
        endcase
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == MS_Y_WRITE) begin
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {vt_r, vs_r, vf_r, 16'(heading_r), pos_y_r, pos_x_r};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // position sum selects pos_x on the x write step and pos_y otherwise
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_period_r <= TICK_PERIOD_RST;
      pos_x_r       <= START_X_RST;
      pos_y_r       <= START_Y_RST;
      heading_r     <= ANGLE_BITS'(START_HEAD_RST);
      out_valid_r   <= 1'b0;
      cnt_r         <= '0;
    end else begin
      tick_period_r <= tick_period_nxt;
      pos_x_r       <= pos_x_nxt;
      pos_y_r       <= pos_y_nxt;
      heading_r     <= heading_nxt;
      out_valid_r   <= out_valid_nxt;
      cnt_r         <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vf_r       <= vf_nxt;
    vs_r       <= vs_nxt;
    vt_r       <= vt_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    cz_r       <= cz_nxt;
    cos_r      <= cos_nxt;
    sin_r      <= sin_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    dfwd_r     <= dfwd_nxt;
    dside_r    <= dside_nxt;
    dturn_r    <= dturn_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
